### rtl/core/cau_pkg.sv
package cau_pkg;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DIV_ZERO = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // one quotient bit per cell
  localparam int unsigned QUO_BITS = 32;

  localparam logic signed [64:0] S32_MAX = 65'sd2147483647;
  localparam logic signed [64:0] S32_MIN = -65'sd2147483648;

  typedef struct packed {
    logic signed [31:0] first_real;
    logic signed [31:0] first_imag;
    logic signed [31:0] second_real;
    logic signed [31:0] second_imag;
    logic [1:0]         operation;
  } in_t;

  typedef struct packed {
    logic signed [31:0] result_real;
    logic signed [31:0] result_imag;
    logic [1:0]         status;
  } out_t;

  // control that travels alongside the divider lanes
  typedef struct packed {
    logic valid;
    logic is_div;
    out_t pre;
  } ctrl_t;

  // one restoring-division lane
  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] num;
    logic [31:0] quo;
    logic        neg;
    logic        big;
  } lane_t;

  // saturate to 32 bits: {overflow, value}
  function automatic logic [32:0] sat32(input logic signed [64:0] v);
    logic [32:0] r;
    if (v > S32_MAX) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < S32_MIN) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

endpackage

### rtl/core/complex_arithmetic_unit.sv
// Channel   Ports               Direction  Meaning
// command   start, operands     in         one transaction when start=1 and busy=0
// status    busy                out        high only while reset is applied
// result    done, result        out        one transaction per command, done for 1 cycle
//
// Four front stages (capture, products, sums, saturate/normalise), a chain of 32
// divider cells producing one quotient bit each, and an output register.
// A new command is taken every cycle while busy is low; the pipeline never stalls.
// Reset is synchronous; it clears the valid bits and holds busy high.
// The receiver cannot stall: every result appears on exactly one cycle.
module complex_arithmetic_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  cau_pkg::in_t  operands,
  output logic          done,
  output cau_pkg::out_t result
);

  localparam int NCELL   = cau_pkg::QUO_BITS;
  localparam int LATENCY = NCELL + 5;

  // chain links: index 0 is the front end output, NCELL the last cell
  cau_pkg::ctrl_t ctrl_c [NCELL+1];
  logic [63:0]    den_c  [NCELL+1];
  cau_pkg::lane_t real_c [NCELL+1];
  cau_pkg::lane_t imag_c [NCELL+1];

  logic accept;
  logic [32:0] fin_r, fin_i;
  cau_pkg::out_t result_next;

  // no commands during reset; otherwise always ready
  assign busy   = rst;
  assign accept = start && !busy;

  cau_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .operands (operands),
    .ctrl     (ctrl_c[0]),
    .den      (den_c[0]),
    .lane_real(real_c[0]),
    .lane_imag(imag_c[0])
  );

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    cau_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl_in (ctrl_c[g]),
      .den_in  (den_c[g]),
      .real_in (real_c[g]),
      .imag_in (imag_c[g]),
      .ctrl_out(ctrl_c[g+1]),
      .den_out (den_c[g+1]),
      .real_out(real_c[g+1]),
      .imag_out(imag_c[g+1])
    );
  end

  // apply sign and saturate a 32-bit quotient magnitude: {overflow, value}
  function automatic logic [32:0] finish(input cau_pkg::lane_t l);
    logic [32:0] r;
    if (l.neg) begin
      if (l.big || (l.quo > 32'h8000_0000)) begin
        r = {1'b1, 32'h8000_0000};
      end else begin
        r = {1'b0, 32'(-l.quo)};
      end
    end else begin
      if (l.big || l.quo[31]) begin
        r = {1'b1, 32'h7FFF_FFFF};
      end else begin
        r = {1'b0, l.quo};
      end
    end
    return r;
  endfunction

  always_comb begin
    fin_r = finish(real_c[NCELL]);
    fin_i = finish(imag_c[NCELL]);
    if (ctrl_c[NCELL].is_div) begin
      result_next = {fin_r[31:0], fin_i[31:0],
                     (fin_r[32] | fin_i[32]) ? cau_pkg::ST_OVERFLOW : cau_pkg::ST_OK};
    end else begin
      result_next = ctrl_c[NCELL].pre;
    end
  end

  // hold the result for exactly one cycle behind done
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl_c[NCELL].valid;
    end
    result <= result_next;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    $past(accept, LATENCY) |-> done)
    else $error("accepted command produced no result");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == cau_pkg::ST_OK || result.status == cau_pkg::ST_DIV_ZERO ||
              result.status == cau_pkg::ST_OVERFLOW))
    else $error("undefined status code");

  a_div_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status == cau_pkg::ST_DIV_ZERO |->
      result.result_real == '0 && result.result_imag == '0)
    else $error("divide by zero result not cleared");

  a_overflow_sat: assert property (@(posedge clk) disable iff (rst)
    done && result.status == cau_pkg::ST_OVERFLOW |->
      result.result_real == 32'sh7FFF_FFFF || result.result_real == 32'sh8000_0000 ||
      result.result_imag == 32'sh7FFF_FFFF || result.result_imag == 32'sh8000_0000)
    else $error("overflow status without a saturated part");

endmodule

### rtl/core/cau_front.sv
module cau_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  cau_pkg::in_t   operands,
  output cau_pkg::ctrl_t ctrl,
  output logic [63:0]    den,
  output cau_pkg::lane_t lane_real,
  output cau_pkg::lane_t lane_imag
);

  localparam int NW = 64 + FRAC_BITS;

  // stage 1: operand capture
  logic         v1;
  cau_pkg::in_t op1;

  // stage 2: products and per-part sums
  logic               v2;
  logic [1:0]         code2;
  logic               dz2;
  logic signed [63:0] ac, bd, bc, ad, cc, dd;
  logic signed [32:0] sr2, si2;

  // stage 3: exact product sums, divisor, and saturated add/sub result
  logic               v3;
  logic [1:0]         code3;
  logic               dz3;
  logic signed [64:0] pr3, pi3, nr3, ni3;
  logic [63:0]        den3;
  cau_pkg::out_t      pre3;

  logic [32:0] sat_r, sat_i;
  logic signed [64:0] sr_ext, si_ext, mr_sh, mi_sh;
  logic [32:0] mul_r, mul_i;
  logic [63:0] mag_r, mag_i;
  logic [NW-1:0] n_r, n_i, hi_r, hi_i;
  cau_pkg::ctrl_t ctrl_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      ctrl.valid <= 1'b0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      ctrl.valid <= v3;
    end
    op1 <= operands;

    code2 <= op1.operation;
    dz2   <= (op1.second_real == '0) && (op1.second_imag == '0);
    ac    <= op1.first_real * op1.second_real;
    bd    <= op1.first_imag * op1.second_imag;
    bc    <= op1.first_imag * op1.second_real;
    ad    <= op1.first_real * op1.second_imag;
    cc    <= op1.second_real * op1.second_real;
    dd    <= op1.second_imag * op1.second_imag;
    if (op1.operation == cau_pkg::OP_SUB) begin
      sr2 <= 33'(op1.first_real) - 33'(op1.second_real);
      si2 <= 33'(op1.first_imag) - 33'(op1.second_imag);
    end else begin
      sr2 <= 33'(op1.first_real) + 33'(op1.second_real);
      si2 <= 33'(op1.first_imag) + 33'(op1.second_imag);
    end

    code3 <= code2;
    dz3   <= dz2;
    pr3   <= 65'(ac) - 65'(bd);
    pi3   <= 65'(bc) + 65'(ad);
    nr3   <= 65'(ac) + 65'(bd);
    ni3   <= 65'(bc) - 65'(ad);
    den3  <= 64'(cc) + 64'(dd);
    pre3  <= {sat_r[31:0], sat_i[31:0],
              (sat_r[32] | sat_i[32]) ? cau_pkg::ST_OVERFLOW : cau_pkg::ST_OK};

    ctrl.is_div <= ctrl_next.is_div;
    ctrl.pre    <= ctrl_next.pre;
    den         <= den3;
    lane_real   <= '{rem: hi_r[63:0], num: n_r[31:0], quo: '0, neg: nr3[64],
                     big: (hi_r >= NW'(den3))};
    lane_imag   <= '{rem: hi_i[63:0], num: n_i[31:0], quo: '0, neg: ni3[64],
                     big: (hi_i >= NW'(den3))};
  end

  always_comb begin
    sr_ext = 65'(sr2);
    si_ext = 65'(si2);
    sat_r  = cau_pkg::sat32(sr_ext);
    sat_i  = cau_pkg::sat32(si_ext);

    mr_sh = pr3 >>> FRAC_BITS;
    mi_sh = pi3 >>> FRAC_BITS;
    mul_r = cau_pkg::sat32(mr_sh);
    mul_i = cau_pkg::sat32(mi_sh);

    mag_r = nr3[64] ? 64'(-nr3) : nr3[63:0];
    mag_i = ni3[64] ? 64'(-ni3) : ni3[63:0];
    n_r   = NW'(mag_r) << FRAC_BITS;
    n_i   = NW'(mag_i) << FRAC_BITS;
    hi_r  = n_r >> cau_pkg::QUO_BITS;
    hi_i  = n_i >> cau_pkg::QUO_BITS;

    ctrl_next = '0;
    case (code3)
      cau_pkg::OP_MUL: begin
        ctrl_next.pre = {mul_r[31:0], mul_i[31:0],
                         (mul_r[32] | mul_i[32]) ? cau_pkg::ST_OVERFLOW : cau_pkg::ST_OK};
      end
      cau_pkg::OP_DIV: begin
        if (dz3) begin
          ctrl_next.pre = {32'd0, 32'd0, cau_pkg::ST_DIV_ZERO};
        end else begin
          ctrl_next.is_div = 1'b1;
        end
      end
      default: begin
        ctrl_next.pre = pre3;
      end
    endcase
  end

endmodule

### rtl/core/cau_div_cell.sv
module cau_div_cell (
  input  logic           clk,
  input  logic           rst,
  input  cau_pkg::ctrl_t ctrl_in,
  input  logic [63:0]    den_in,
  input  cau_pkg::lane_t real_in,
  input  cau_pkg::lane_t imag_in,
  output cau_pkg::ctrl_t ctrl_out,
  output logic [63:0]    den_out,
  output cau_pkg::lane_t real_out,
  output cau_pkg::lane_t imag_out
);

  cau_pkg::lane_t real_next, imag_next;
  logic [63:0] tr_r, tr_i;
  logic ge_r, ge_i;

  // shift one numerator bit in, subtract the divisor where it fits
  always_comb begin
    tr_r = {real_in.rem[62:0], real_in.num[31]};
    tr_i = {imag_in.rem[62:0], imag_in.num[31]};
    ge_r = tr_r >= den_in;
    ge_i = tr_i >= den_in;
    real_next      = real_in;
    real_next.rem  = ge_r ? tr_r - den_in : tr_r;
    real_next.num  = {real_in.num[30:0], 1'b0};
    real_next.quo  = {real_in.quo[30:0], ge_r};
    imag_next      = imag_in;
    imag_next.rem  = ge_i ? tr_i - den_in : tr_i;
    imag_next.num  = {imag_in.num[30:0], 1'b0};
    imag_next.quo  = {imag_in.quo[30:0], ge_i};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out.valid <= 1'b0;
    end else begin
      ctrl_out.valid <= ctrl_in.valid;
    end
    ctrl_out.is_div <= ctrl_in.is_div;
    ctrl_out.pre    <= ctrl_in.pre;
    den_out         <= den_in;
    real_out        <= real_next;
    imag_out        <= imag_next;
  end

endmodule
